/* rtl/core/brah_pkg.sv */
package brah_pkg;

  localparam int unsigned HistoryDepth = 24;
  localparam int unsigned IdxW = $clog2(HistoryDepth);
  localparam logic [15:0] BucketSecondsReset = 16'd600;
  localparam logic [7:0] RateClamp = 8'd200;
  localparam logic [6:0] ScaleTop = 7'd127;
  localparam logic [7:0] CountMax = 8'd255;
  // (x * ScaleRecip) >> ScaleShift equals x / 200 for x up to 200 * 127
  localparam logic [13:0] ScaleRecip = 14'd10486;
  localparam int unsigned ScaleShift = 21;

  localparam logic KindSample = 1'b0;
  localparam logic KindDump = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] time_seconds;
    logic [7:0]  rate_bpm;
  } req_t;

  typedef struct packed {
    logic [4:0] point_index;
    logic [6:0] point_value;
    logic       point_valid;
    logic       last;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        dump;
    logic [31:0] bucket;
    logic [7:0]  rate;
  } cmd_t;

endpackage

/* rtl/core/brah_front.sv */
module brah_front import brah_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] bucket_seconds_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  // serial restoring divide of time by bucket length, one quotient bit a cycle
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [7:0]  rate_q, rate_d;
  logic        out_v_q, out_v_d;
  cmd_t        out_q, out_d;
  logic [16:0] trial;
  logic [16:0] shifted;

  assign req_ready_o = !busy_q && !out_v_q;
  assign cmd_valid_o = out_v_q;
  assign cmd_o = out_q;
  assign shifted = {rem_q, quo_q[31]};
  assign trial = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    rate_d = rate_q;
    out_v_d = out_v_q;
    out_d = out_q;
    if (out_v_q && cmd_ready_i) out_v_d = 1'b0;
    if (req_valid_i && req_ready_o) begin
      if (req_i.kind == KindDump) begin
        out_v_d = 1'b1;
        out_d = '{dump: 1'b1, bucket: '0, rate: '0};
      end else begin
        busy_d = 1'b1;
        cnt_d = 6'd0;
        quo_d = req_i.time_seconds;
        rem_d = '0;
        div_d = (bucket_seconds_i == 16'd0) ? 16'd1 : bucket_seconds_i;
        rate_d = req_i.rate_bpm;
      end
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_d = trial[15:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        out_v_d = 1'b1;
        out_d = '{dump: 1'b0, bucket: quo_d, rate: rate_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      out_v_q <= out_v_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    rate_q <= rate_d;
    out_q <= out_d;
  end

endmodule

/* rtl/core/brah_back.sv */
module brah_back import brah_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StShift = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StScale = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;
  localparam logic [2:0] StDump  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [6:0]  hval_q [HistoryDepth];
  logic [6:0]  hval_d [HistoryDepth];
  logic [HistoryDepth-1:0] hvld_q, hvld_d;
  logic [31:0] cur_q, cur_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        rdy_q, rdy_d;
  cmd_t        cmd_q, cmd_d;
  logic [31:0] dist_q, dist_d;
  // average divide: quotient of 16 bit sum by 8 bit count
  logic [15:0] aq_q, aq_d;
  logic [8:0]  ar_q, ar_d;
  logic [4:0]  step_q, step_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic        ov_q, ov_d;
  rsp_t        o_q, o_d;
  logic [9:0]  atrial;
  logic [9:0]  ash;
  logic [7:0]  avg;
  logic [14:0] prod_q, prod_d;
  logic [27:0] recip;

  assign cmd_ready_o = (st_q == StIdle) && !ov_q;
  assign rsp_valid_o = ov_q;
  assign rsp_o = o_q;
  assign ash = {ar_q, aq_q[15]};
  assign atrial = ash - {2'b0, cnt_q};
  assign avg = (aq_q > {8'd0, RateClamp}) ? RateClamp : aq_q[7:0];
  assign recip = 28'(prod_q) * 28'(ScaleRecip);

  always_comb begin
    st_d = st_q;
    hval_d = hval_q;
    hvld_d = hvld_q;
    cur_d = cur_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    rdy_d = rdy_q;
    cmd_d = cmd_q;
    dist_d = dist_q;
    aq_d = aq_q;
    ar_d = ar_q;
    step_d = step_q;
    idx_d = idx_q;
    ov_d = ov_q;
    o_d = o_q;
    prod_d = prod_q;
    if (ov_q && rsp_ready_i) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (cmd_valid_i && cmd_ready_o) begin
          cmd_d = cmd_i;
          idx_d = '0;
          if (cmd_i.dump) begin
            st_d = StDump;
          end else if (!rdy_q || cmd_i.bucket < cur_q) begin
            hvld_d = '0;
            cur_d = cmd_i.bucket;
            sum_d = '0;
            cnt_d = '0;
            rdy_d = 1'b1;
            st_d = StEmit;
          end else if (cmd_i.bucket > cur_q) begin
            dist_d = cmd_i.bucket - cur_q;
            cur_d = cmd_i.bucket;
            sum_d = '0;
            cnt_d = '0;
            st_d = StShift;
          end else begin
            st_d = StEmit;
          end
        end
      end
      StShift: begin
        // one position per cycle
        if (dist_q >= 32'(HistoryDepth)) begin
          hvld_d = '0;
          st_d = StEmit;
        end else if (dist_q == 32'd0) begin
          st_d = StEmit;
        end else begin
          for (int i = HistoryDepth - 1; i > 0; i--) hval_d[i] = hval_q[i-1];
          hvld_d = {hvld_q[HistoryDepth-2:0], 1'b0};
          dist_d = dist_q - 32'd1;
        end
      end
      StEmit: begin
        // sample path: update sum first if the rate counts
        if (cmd_q.rate != 8'd0 && cnt_q < CountMax && step_q == 5'd0) begin
          sum_d = sum_q + {8'd0, cmd_q.rate};
          cnt_d = cnt_q + 8'd1;
          cmd_d.rate = 8'd0;
          aq_d = sum_q + {8'd0, cmd_q.rate};
          ar_d = '0;
          step_d = 5'd0;
          st_d = StDiv;
        end else if (!ov_q) begin
          ov_d = 1'b1;
          o_d = '{point_index: '0, point_value: hvld_q[0] ? hval_q[0] : 7'd0,
                  point_valid: hvld_q[0], last: 1'b1};
          step_d = 5'd0;
          st_d = StIdle;
        end
      end
      StDiv: begin
        if (!atrial[9]) begin
          ar_d = atrial[8:0];
          aq_d = {aq_q[14:0], 1'b1};
        end else begin
          ar_d = ash[8:0];
          aq_d = {aq_q[14:0], 1'b0};
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) st_d = StScale;
      end
      StScale: begin
        // step 16: multiply by 127, then 17: divide by 200 via reciprocal multiply
        if (step_q == 5'd16) begin
          prod_d = 15'(avg * ScaleTop);
          step_d = 5'd17;
        end else begin
          hval_d[0] = recip[ScaleShift+6:ScaleShift];
          hvld_d[0] = 1'b1;
          step_d = 5'd1;
          st_d = StEmit;
        end
      end
      StDump: begin
        if (!ov_q || rsp_ready_i) begin
          ov_d = 1'b1;
          o_d = '{point_index: 5'(idx_q),
                  point_value: hvld_q[idx_q] ? hval_q[idx_q] : 7'd0,
                  point_valid: hvld_q[idx_q],
                  last: idx_q == IdxW'(HistoryDepth - 1)};
          if (idx_q == IdxW'(HistoryDepth - 1)) st_d = StIdle;
          else idx_d = idx_q + 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      hvld_q <= '0;
      cur_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      rdy_q <= 1'b0;
      ov_q <= 1'b0;
      step_q <= '0;
      idx_q <= '0;
    end else begin
      st_q <= st_d;
      hvld_q <= hvld_d;
      cur_q <= cur_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      rdy_q <= rdy_d;
      ov_q <= ov_d;
      step_q <= step_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hval_q <= hval_d;
    cmd_q <= cmd_d;
    dist_q <= dist_d;
    aq_q <= aq_d;
    ar_q <= ar_d;
    o_q <= o_d;
    prod_q <= prod_d;
  end

endmodule

/* rtl/core/bucketed_rate_average_history.sv */
// sample: about 34 cycles in the front divider, then up to 24 shift cycles
// plus about 20 cycles of average divide and scaling in the back
// dump: 24 results, one per cycle while the output is taken
// one request in each part at a time; the two parts overlap via a one-entry queue
// reset: history invalid, bucket length 600, first sample restarts the history
module bucketed_rate_average_history import brah_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o
);

  logic [15:0] bsec_q;
  logic        cv, cr;
  cmd_t        c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsec_q <= BucketSecondsReset;
    end else if (cfg_we_i) begin
      bsec_q <= cfg_wdata_i;
    end
  end

  brah_front u_front (
    .clk_i, .rst_ni, .bucket_seconds_i(bsec_q),
    .req_valid_i(in_valid_i), .req_ready_o(in_ready_o), .req_i(in_data_i),
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_o(c)
  );

  brah_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cv), .cmd_ready_o(cr), .cmd_i(c),
    .rsp_valid_o(out_valid_o), .rsp_ready_i(out_ready_i), .rsp_o(out_data_o)
  );

endmodule
